/* design/bchs_pkg.sv */
// ----------------------------------------------------------------------------
// bchs_pkg
// Shared types and constants for the button click and hold scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package bchs_pkg;

    localparam int BUTTONS   = 4;
    localparam int TIME_BITS = 16;

    // Widths of the request and result fields.
    localparam int PIN_BITS      = 4;
    localparam int MASK_BITS     = 4;
    localparam int INTERVAL_BITS = 8;
    localparam int HOLD_BITS     = 15;
    localparam int CFG_IDX_BITS  = 1;

    // Compare widths that hold both a time difference and a setting.
    localparam int SCAN_CMP_BITS = (TIME_BITS > INTERVAL_BITS) ? TIME_BITS : INTERVAL_BITS;
    localparam int HOLD_CMP_BITS = (TIME_BITS > HOLD_BITS) ? TIME_BITS : HOLD_BITS;

    typedef logic [TIME_BITS-1:0]     t_time;
    typedef logic [INTERVAL_BITS-1:0] t_interval;
    typedef logic [HOLD_BITS-1:0]     t_hold;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCAN_INTERVAL = 1'b0,
        CFG_HOLD_TIME     = 1'b1
    } t_cfg_idx;

    // Per-button event state.
    typedef enum logic [1:0] {
        EV_IDLE     = 2'd0,
        EV_CLICK    = 2'd1,
        EV_PRESSING = 2'd2,
        EV_HELD     = 2'd3
    } t_event;

    // Control broadcast from the timer to every lane.
    typedef struct packed {
        logic  accept;
        logic  scan;
        t_time now;
    } t_lane_ctl;

    // One result as it sits in the output buffer.
    typedef struct packed {
        logic [MASK_BITS-1:0] click;
        logic [MASK_BITS-1:0] held;
    } t_result;

endpackage

`default_nettype wire

/* design/button_click_hold_scanner_unit.sv */
// ----------------------------------------------------------------------------
// button_click_hold_scanner_unit
// Click and long-press detector for a bank of push buttons.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request carries the active-low pin levels, a one-millisecond
//   tick flag and a mask of pending clicks to acknowledge. It is accepted when
//   i_in_valid and o_in_ready are both high. Every request yields exactly one
//   result (click mask and held mask) on the output channel, taken when
//   o_out_valid and i_out_ready are both high.
//   The result of an accepted request is registered in the output register,
//   or in the skid stage while an earlier result waits. A new request can
//   be accepted every cycle unless the skid stage is full; the whole update
//   of all buttons (one lane per button, plus the shared millisecond timer) completes in the accepting cycle.
//   The output register is backed by a one-entry skid stage, so a request is
//   still accepted while a result waits; o_in_ready drops only once the skid
//   stage is also full, and rises again as soon as the receiver takes one.
//   Configuration writes (scan interval, hold time) use their own channel,
//   which is always ready; write them only while no request is in flight.
//   Synchronous reset clears the timer, all button state and both buffers,
//   and restores a 10 ms scan interval and a 1000 ms hold time.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_hold_scanner_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Input request channel.
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [bchs_pkg::PIN_BITS-1:0]      i_pin_levels,
    input  wire                                i_tick,
    input  wire  [bchs_pkg::PIN_BITS-1:0]      i_clear_clicks,
    // Result channel.
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic [bchs_pkg::MASK_BITS-1:0]     o_click_mask,
    output logic [bchs_pkg::MASK_BITS-1:0]     o_held_mask,
    // Configuration write channel.
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [bchs_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [bchs_pkg::HOLD_BITS-1:0]     i_cfg_data
);
    import bchs_pkg::*;

    t_interval r_scan_interval;
    t_hold     r_hold_time;

    logic               w_accept;
    t_lane_ctl          w_ctl;
    logic [BUTTONS-1:0] w_pressed;
    logic [BUTTONS-1:0] w_clear;
    logic [BUTTONS-1:0] w_click;
    logic [BUTTONS-1:0] w_held;
    t_result            w_result;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers. The decoder covers every index the port can
    // carry, so no write can land outside the register list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_interval <= t_interval'(10);
            r_hold_time     <= t_hold'(1000);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCAN_INTERVAL: r_scan_interval <= i_cfg_data[INTERVAL_BITS-1:0];
                CFG_HOLD_TIME:     r_hold_time     <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Shared timer decides whether this request triggers a scan.
    bchs_timer u_timer (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_tick          (i_tick),
        .i_scan_interval (r_scan_interval),
        .o_ctl           (w_ctl)
    );

    // One lane per button. A pin past the field width reads as pressed and
    // its acknowledge bit as clear.
    for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
        if (i < PIN_BITS) begin : g_pin
            assign w_pressed[i] = !i_pin_levels[i];
            assign w_clear[i]   = i_clear_clicks[i];
        end else begin : g_nopin
            assign w_pressed[i] = 1'b1;
            assign w_clear[i]   = 1'b0;
        end

        bchs_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_pressed   (w_pressed[i]),
            .i_clear     (w_clear[i]),
            .i_hold_time (r_hold_time),
            .o_click     (w_click[i]),
            .o_held      (w_held[i])
        );
    end

    // Merge lane flags and buffer the result toward the receiver.
    bchs_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_click     (w_click),
        .i_held      (w_held),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_click_mask = w_result.click;
    assign o_held_mask  = w_result.held;

endmodule

`default_nettype wire

/* design/bchs_timer.sv */
// ----------------------------------------------------------------------------
// bchs_timer
// Millisecond counter and scan scheduler shared by all button lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module bchs_timer (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_accept,
    input  wire                        i_tick,
    input  wire  bchs_pkg::t_interval  i_scan_interval,
    output bchs_pkg::t_lane_ctl        o_ctl
);
    import bchs_pkg::*;

    t_time r_now;
    t_time r_last_scan;
    t_time n_now;
    t_time w_diff;
    logic  w_scan;

    // The tick advances time first; the scan test uses the new time.
    assign n_now  = i_tick ? t_time'(r_now + 1'b1) : r_now;
    assign w_diff = t_time'(n_now - r_last_scan);
    assign w_scan = i_tick &&
        (SCAN_CMP_BITS'(w_diff) >= SCAN_CMP_BITS'(i_scan_interval));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_last_scan <= '0;
        end else if (i_accept) begin
            r_now <= n_now;
            if (w_scan) begin
                r_last_scan <= n_now;
            end
        end
    end

    assign o_ctl.accept = i_accept;
    assign o_ctl.scan   = w_scan;
    assign o_ctl.now    = n_now;

endmodule

`default_nettype wire

/* design/bchs_lane.sv */
// ----------------------------------------------------------------------------
// bchs_lane
// State and update logic of one push button.
// ----------------------------------------------------------------------------
`default_nettype none

module bchs_lane (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  bchs_pkg::t_lane_ctl i_ctl,
    input  wire                    i_pressed,
    input  wire                    i_clear,
    input  wire  bchs_pkg::t_hold  i_hold_time,
    output logic                   o_click,
    output logic                   o_held
);
    import bchs_pkg::*;

    logic   r_was_pressed;
    t_event r_code;
    t_time  r_start;

    t_event w_code_clr;
    t_event n_code;
    t_time  n_start;
    t_time  w_len;
    logic   w_long;

    always_comb begin
        // An acknowledge only removes a pending click.
        w_code_clr = (i_clear && (r_code == EV_CLICK)) ? EV_IDLE : r_code;
        n_start    = (i_pressed && (w_code_clr == EV_IDLE)) ? i_ctl.now : r_start;
        w_len      = t_time'(i_ctl.now - n_start);
        w_long     = HOLD_CMP_BITS'(w_len) > HOLD_CMP_BITS'(i_hold_time);
        n_code     = w_code_clr;
        if (i_ctl.scan) begin
            if (!i_pressed && r_was_pressed) begin
                n_code = (w_code_clr == EV_HELD) ? EV_IDLE : EV_CLICK;
            end else if (i_pressed && r_was_pressed) begin
                if (w_long) begin
                    n_code = EV_HELD;
                end else if (w_code_clr != EV_HELD) begin
                    n_code = EV_PRESSING;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_pressed <= 1'b0;
            r_code        <= EV_IDLE;
            r_start       <= '0;
        end else if (i_ctl.accept) begin
            r_code <= n_code;
            if (i_ctl.scan) begin
                r_was_pressed <= i_pressed;
                r_start       <= n_start;
            end
        end
    end

    // The result reflects the state after this request's update.
    assign o_click = (n_code == EV_CLICK);
    assign o_held  = (n_code == EV_HELD);

endmodule

`default_nettype wire

/* design/bchs_outbuf.sv */
// ----------------------------------------------------------------------------
// bchs_outbuf
// Merges the lane flags into one result and holds it in an output register
// backed by a skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bchs_outbuf (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_accept,
    input  wire  [bchs_pkg::BUTTONS-1:0] i_click,
    input  wire  [bchs_pkg::BUTTONS-1:0] i_held,
    input  wire                          i_out_ready,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    output bchs_pkg::t_result            o_result
);
    import bchs_pkg::*;

    t_result w_new;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    w_take;

    // Buttons past the field width are dropped; missing buttons read zero.
    for (genvar j = 0; j < MASK_BITS; j++) begin : g_merge
        if (j < BUTTONS) begin : g_lane
            assign w_new.click[j] = i_click[j];
            assign w_new.held[j]  = i_held[j];
        end else begin : g_none
            assign w_new.click[j] = 1'b0;
            assign w_new.held[j]  = 1'b0;
        end
    end

    assign w_take     = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_accept) begin
                r_out <= w_new;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (i_accept) begin
            if (r_out_valid) begin
                r_skid       <= w_new;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= w_new;
                r_out_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_out_valid)
        else $error("accepted request left no result");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("stalled request not parked in skid stage");

    a_click_held_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.click & r_out.held) == '0))
        else $error("button reported both clicked and held");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button click and hold scanner.
// A short stimulus table covers reset behavior, missing ticks, holds,
// releases, click acknowledges and re-presses. Random phases then sweep the
// scan interval and hold time, including their extremes. Every result is
// compared with its typed-in value or a cycle-free software copy of the scanner.
// ----------------------------------------------------------------------------

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import bchs_pkg::*;

    // Upper bound on the run length, many times what a normal run needs.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int MAX_REPORTS = 10;
    localparam int DIR_ROWS    = 24;
    // Rows before this one run with the reset settings.
    localparam int TUNED_ROW   = 3;

    // One line of the stimulus table. When known is set, the result is typed
    // in directly; otherwise it comes from the scanner copy.
    typedef struct packed {
        logic [PIN_BITS-1:0]  pins;
        logic                 tick;
        logic [PIN_BITS-1:0]  clr;
        logic                 known;
        logic [MASK_BITS-1:0] click;
        logic [MASK_BITS-1:0] held;
    } t_row;

    // DUT connections. Every input starts at a known level.
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_ready;
    logic [PIN_BITS-1:0]  i_pin_levels   = '1;
    logic                 i_tick         = 1'b0;
    logic [PIN_BITS-1:0]  i_clear_clicks = '0;
    logic                 o_out_valid;
    logic                 i_out_ready    = 1'b0;
    logic [MASK_BITS-1:0] o_click_mask;
    logic [MASK_BITS-1:0] o_held_mask;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index    = CFG_SCAN_INTERVAL;
    logic [HOLD_BITS-1:0] i_cfg_data     = '0;

    // Scanner copy: settings, timer and per-button state.
    t_interval cfg_scan;
    t_hold     cfg_hold;
    t_time     tm_now;
    t_time     tm_last_scan;
    logic      btn_down [BUTTONS];
    t_event    btn_state [BUTTONS];
    t_time     btn_press_start [BUTTONS];

    // Masks still owed by the DUT, oldest first.
    t_result expected_masks [$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    // Chance in percent that either side sits out a cycle.
    int unsigned idle_pct = 38;
    // Pin levels carried from one random request to the next.
    logic [PIN_BITS-1:0] cur_pins = '1;

    t_row directed_rows [DIR_ROWS] = '{
        // Reset settings: 10 ms interval, so nothing is scanned yet.
        '{4'hF, 1'b0, 4'h0, 1'b1, 4'h0, 4'h0},
        '{4'h0, 1'b0, 4'h0, 1'b1, 4'h0, 4'h0},
        '{4'h0, 1'b1, 4'h0, 1'b1, 4'h0, 4'h0},
        // From here: zero interval (scan on every tick) and 1 ms hold time.
        '{4'h0, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'h0, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'h0, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'h0, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        // Acknowledge with no click pending, all buttons held.
        '{4'h0, 1'b0, 4'hF, 1'b0, 4'h0, 4'h0},
        // Release after a hold goes back to idle without a click.
        '{4'hF, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hA, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hF, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'h5, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hF, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hF, 1'b0, 4'h5, 1'b0, 4'h0, 4'h0},
        // Everything released and acknowledged: both masks are empty.
        '{4'hF, 1'b0, 4'hF, 1'b1, 4'h0, 4'h0},
        '{4'hE, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hF, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        // New press while the click is pending keeps the old start time.
        '{4'hE, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hE, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hE, 1'b1, 4'h1, 1'b0, 4'h0, 4'h0},
        '{4'h7, 1'b1, 4'h8, 1'b0, 4'h0, 4'h0},
        '{4'h0, 1'b1, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hF, 1'b0, 4'h0, 1'b0, 4'h0, 4'h0},
        '{4'hF, 1'b1, 4'hF, 1'b0, 4'h0, 4'h0}
    };

    button_click_hold_scanner_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pin_levels   (i_pin_levels),
        .i_tick         (i_tick),
        .i_clear_clicks (i_clear_clicks),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_click_mask   (o_click_mask),
        .o_held_mask    (o_held_mask),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Timeout guard. A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_masks.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Puts the scanner copy back to its reset state.
    task automatic reset_scanner_copy();
        cfg_scan     = t_interval'(10);
        cfg_hold     = t_hold'(1000);
        tm_now       = '0;
        tm_last_scan = '0;
        for (int b = 0; b < BUTTONS; b++) begin
            btn_down[b]        = 1'b0;
            btn_state[b]       = EV_IDLE;
            btn_press_start[b] = '0;
        end
    endtask

    // Applies one accepted request to the scanner copy and returns the
    // click and held masks it leaves behind.
    function automatic t_result predict_masks(logic [PIN_BITS-1:0] pins, logic tick,
                                              logic [PIN_BITS-1:0] clr);
        t_result res;
        t_time   since_scan;
        t_time   press_len;
        logic    pressed;
        res = '0;
        // Acknowledges come first, and only touch pending clicks.
        for (int b = 0; b < BUTTONS; b++) begin
            if (clr[b] && btn_state[b] == EV_CLICK)
                btn_state[b] = EV_IDLE;
        end
        if (tick) begin
            tm_now     = tm_now + 1'b1;
            since_scan = tm_now - tm_last_scan;
            if (since_scan >= cfg_scan) begin
                tm_last_scan = tm_now;
                for (int b = 0; b < BUTTONS; b++) begin
                    pressed = !pins[b];
                    // A pressed idle button restarts its press clock on every scan.
                    if (pressed && btn_state[b] == EV_IDLE)
                        btn_press_start[b] = tm_now;
                    if (!pressed && btn_down[b]) begin
                        btn_state[b] = (btn_state[b] == EV_HELD) ? EV_IDLE : EV_CLICK;
                    end else if (pressed && btn_down[b]) begin
                        press_len = tm_now - btn_press_start[b];
                        if (press_len > cfg_hold)
                            btn_state[b] = EV_HELD;
                        else if (btn_state[b] != EV_HELD)
                            btn_state[b] = EV_PRESSING;
                    end
                    btn_down[b] = pressed;
                end
            end
        end
        for (int b = 0; b < BUTTONS; b++) begin
            res.click[b] = (btn_state[b] == EV_CLICK);
            res.held[b]  = (btn_state[b] == EV_HELD);
        end
        return res;
    endfunction

    // Offers one request on the input channel. Called and returned at a
    // falling edge; valid is left high so a following request can continue
    // without a gap. The expectation is recorded at the accepting edge.
    task automatic issue_request(logic [PIN_BITS-1:0] pins, logic tick,
                                 logic [PIN_BITS-1:0] clr, logic known,
                                 t_result known_masks);
        t_result predicted;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pin_levels   <= pins;
        i_tick         <= tick;
        i_clear_clicks <= clr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predicted = predict_masks(pins, tick, clr);
        expected_masks.push_back(known ? known_masks : predicted);
        @(negedge i_clk);
    endtask

    // Builds one random request. Most requests only flip a few pins so that
    // presses last long enough to become clicks and holds; a share of them
    // are bounce noise with fully random pins.
    task automatic issue_random_request(int unsigned tick_pct, int unsigned flip_rate,
                                        int unsigned noise_pct, int unsigned clr_pct);
        logic [PIN_BITS-1:0] clr;
        logic                tick;
        if ($urandom_range(99) < noise_pct) begin
            cur_pins = PIN_BITS'($urandom_range(15));
        end else begin
            // flip_rate is in parts per 100000 for each pin.
            for (int b = 0; b < PIN_BITS; b++) begin
                if ($urandom_range(99999) < flip_rate)
                    cur_pins[b] = ~cur_pins[b];
            end
        end
        tick = ($urandom_range(99) < tick_pct);
        clr  = ($urandom_range(99) < clr_pct) ? PIN_BITS'($urandom_range(15)) : '0;
        issue_request(cur_pins, tick, clr, 1'b0, '0);
    endtask

    // Stops sending and waits until the DUT has returned every result.
    // Each request yields a result, so an empty queue means the block is idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_masks.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes both registers back to back; only called while idle.
    task automatic write_settings(t_interval scan, t_hold hold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SCAN_INTERVAL;
        i_cfg_data  <= HOLD_BITS'(scan);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_scan = scan;
        @(negedge i_clk);
        i_cfg_index <= CFG_HOLD_TIME;
        i_cfg_data  <= hold;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        cfg_hold = hold;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result receiver: ready is redrawn at every falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end

    // Result checker: every accepted result is matched with the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_masks.size() == 0) begin
                fail_count <= fail_count + 1;
                if (fail_count < MAX_REPORTS)
                    $display("unexpected result at cycle %0d: click=%h held=%h",
                             cycle_count, o_click_mask, o_held_mask);
            end else begin
                want = expected_masks.pop_front();
                if (o_click_mask !== want.click || o_held_mask !== want.held) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < MAX_REPORTS)
                        $display("mismatch at cycle %0d: click exp=%h got=%h, held exp=%h got=%h",
                                 cycle_count, want.click, o_click_mask,
                                 want.held, o_held_mask);
                end
            end
        end
    end

    initial begin
        reset_scanner_copy();
        // Reset is released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. The first rows see the reset settings; the rest run
        // with a zero interval and a 1 ms hold time.
        for (int row = 0; row < DIR_ROWS; row++) begin
            if (row == TUNED_ROW) begin
                drain_results();
                write_settings(t_interval'(0), t_hold'(1));
            end
            issue_request(directed_rows[row].pins, directed_rows[row].tick,
                          directed_rows[row].clr, directed_rows[row].known,
                          '{click: directed_rows[row].click, held: directed_rows[row].held});
        end

        // Fastest scanning with short holds. Halfway through, the sender
        // waits until the output side has fully caught up.
        drain_results();
        write_settings(t_interval'(1), t_hold'($urandom_range(2, 12)));
        for (int n = 0; n < 300; n++) begin
            if (n == 150)
                drain_results();
            issue_random_request(80, 5000, 5, 20);
        end

        // A long stretch where neither side ever idles.
        drain_results();
        idle_pct = 0;
        write_settings(t_interval'($urandom_range(2, 6)), t_hold'($urandom_range(5, 40)));
        for (int n = 0; n < 400; n++)
            issue_random_request(90, 3000, 5, 15);

        // Zero interval and a 1 ms hold time, with sparse ticks.
        drain_results();
        idle_pct = 38;
        write_settings(t_interval'(0), t_hold'(1));
        for (int n = 0; n < 200; n++)
            issue_random_request(50, 8000, 10, 30);

        // Heavy bouncing: many presses are broken off by noise.
        drain_results();
        write_settings(t_interval'(3), t_hold'(20));
        for (int n = 0; n < 400; n++)
            issue_random_request(85, 1500, 25, 25);

        // Longest interval and hold time. Pins change rarely and scans are
        // sparse, so presses stay below the hold time.
        drain_results();
        write_settings(t_interval'(255), t_hold'(32767));
        for (int n = 0; n < 200; n++)
            issue_random_request(97, 5, 0, 5);

        // Quick scanning with moderate holds.
        drain_results();
        write_settings(t_interval'(1), t_hold'(50));
        for (int n = 0; n < 400; n++)
            issue_random_request(95, 2000, 5, 15);

        // Let the last results come back, then idle before the final verdict.
        i_in_valid <= 1'b0;
        while (expected_masks.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0 && expected_masks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/bchs_pkg.sv
design/bchs_timer.sv
design/bchs_lane.sv
design/bchs_outbuf.sv
design/button_click_hold_scanner_unit.sv
dv/tb_top.sv
